/* hw/rtl/bey_pkg.sv */
`timescale 1ns / 1ps

package bey_pkg;

    localparam int FRAC_BITS      = 15;
    localparam int ITERATIONS_DEF = 12;
    localparam int ONE            = 1 << FRAC_BITS;
    localparam int EPSILON        = ONE / 2000;
    localparam int T_LIM          = 4 * ONE;
    localparam longint H_LIM      = 64'sd1 <<< 36;

    localparam int XW = 16;
    localparam int TW = 20;
    localparam int KW = 21;
    localparam int HW = 38;
    localparam int VW = HW + 2;
    localparam int EW = 32;

    typedef struct packed {
        logic                 valid;
        logic                 diag;
        logic                 done;
        logic [XW-1:0]        x;
        logic [XW-1:0]        ay;
        logic [XW-1:0]        by;
        logic signed [KW-1:0] k0;
        logic signed [KW-1:0] k1;
        logic signed [KW-1:0] k2;
        logic signed [TW-1:0] t;
    } bey_item_t;

    function automatic logic signed [HW-1:0] sat_h(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] hi;
        hi = VW'(H_LIM);
        if (v > hi) begin
            return HW'(hi);
        end
        if (v < -hi) begin
            return HW'(-hi);
        end
        return HW'(v);
    endfunction

endpackage

/* hw/rtl/bey_iter.sv */
`timescale 1ns / 1ps

module bey_iter (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  bey_pkg::bey_item_t in_item,
    output bey_pkg::bey_item_t out_item
);
    import bey_pkg::*;

    localparam logic signed [VW-1:0] EPS_V  = VW'(EPSILON);
    localparam logic signed [VW-1:0] TLIM_V = VW'(T_LIM);

    bey_item_t a_reg, b_reg, c_reg, c_next;
    logic signed [HW-1:0] ha_reg, ha_next, hb_reg, hb_next, h3;
    logic signed [KW+TW-1:0] prod_a;
    logic signed [HW+TW-1:0] prod_b, prod_c;
    logic signed [VW-1:0] f, half, tn;
    logic near;

    always_comb begin
        prod_a  = in_item.k0 * in_item.t;
        ha_next = sat_h(VW'(prod_a >>> FRAC_BITS) + VW'(in_item.k1));
        prod_b  = ha_reg * a_reg.t;
        hb_next = sat_h(VW'(prod_b >>> FRAC_BITS) + VW'(a_reg.k2));
        prod_c  = hb_reg * b_reg.t;
        h3      = sat_h(VW'(prod_c >>> FRAC_BITS));
        f       = VW'(h3) - VW'($signed({1'b0, b_reg.x}));
        near    = (f <= EPS_V) && (f >= -EPS_V);
        half    = (f + $signed({{(VW-1){1'b0}}, f[VW-1]})) >>> 1;
        tn      = VW'(b_reg.t) - half;
        c_next  = b_reg;
        if (!b_reg.done) begin
            if (near) begin
                c_next.done = 1'b1;
            end else if (tn > TLIM_V) begin
                c_next.t = TW'(TLIM_V);
            end else if (tn < -TLIM_V) begin
                c_next.t = TW'(-TLIM_V);
            end else begin
                c_next.t = TW'(tn);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg.valid <= 1'b0;
            b_reg.valid <= 1'b0;
            c_reg.valid <= 1'b0;
        end else if (en) begin
            a_reg  <= in_item;
            ha_reg <= ha_next;
            b_reg  <= a_reg;
            hb_reg <= hb_next;
            c_reg  <= c_next;
        end
    end

    assign out_item = c_reg;

endmodule

/* hw/rtl/bey_eval.sv */
`timescale 1ns / 1ps

module bey_eval (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  bey_pkg::bey_item_t         in_item,
    output logic                       out_valid,
    output logic [bey_pkg::XW-1:0]     out_y
);
    import bey_pkg::*;

    localparam logic signed [EW-1:0] ONE_V = EW'(ONE);

    bey_item_t e1_reg, e2_reg, e3_reg;
    logic signed [EW-1:0] r_reg, t2_reg, rr_reg;
    logic signed [EW-1:0] t3_reg, pa_reg, pb_reg;
    logic signed [EW-1:0] t3b_reg, term2_reg, term3_reg;
    logic signed [EW-1:0] r_next, t2_next, rr_next, t3_next, pa_next, pb_next;
    logic signed [EW-1:0] term2_next, term3_next, sum;
    logic signed [2*EW-1:0] m_tt, m_rr, m_t3, m_pa, m_pb, m_q2, m_q3;
    logic valid_reg;
    logic [XW-1:0] y_reg, y_next;

    always_comb begin
        r_next     = ONE_V - EW'(in_item.t);
        m_tt       = EW'(in_item.t) * EW'(in_item.t);
        t2_next    = EW'(m_tt >>> FRAC_BITS);
        m_rr       = r_next * r_next;
        rr_next    = EW'(m_rr >>> FRAC_BITS);
        m_t3       = t2_reg * EW'(e1_reg.t);
        t3_next    = EW'(m_t3 >>> FRAC_BITS);
        m_pa       = t2_reg * r_reg;
        pa_next    = EW'(m_pa >>> FRAC_BITS);
        m_pb       = EW'(e1_reg.t) * rr_reg;
        pb_next    = EW'(m_pb >>> FRAC_BITS);
        m_q2       = pa_reg * EW'($signed({1'b0, e2_reg.by}));
        term2_next = 3 * EW'(m_q2 >>> FRAC_BITS);
        m_q3       = pb_reg * EW'($signed({1'b0, e2_reg.ay}));
        term3_next = 3 * EW'(m_q3 >>> FRAC_BITS);
        if (e3_reg.diag) begin
            sum = EW'($signed({1'b0, e3_reg.x}));
        end else begin
            sum = t3b_reg + term2_reg + term3_reg;
        end
        if (sum < 0) begin
            y_next = '0;
        end else if (sum > ONE_V) begin
            y_next = XW'(ONE_V);
        end else begin
            y_next = XW'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_reg.valid <= 1'b0;
            e2_reg.valid <= 1'b0;
            e3_reg.valid <= 1'b0;
            valid_reg    <= 1'b0;
        end else if (en) begin
            e1_reg    <= in_item;
            r_reg     <= r_next;
            t2_reg    <= t2_next;
            rr_reg    <= rr_next;
            e2_reg    <= e1_reg;
            t3_reg    <= t3_next;
            pa_reg    <= pa_next;
            pb_reg    <= pb_next;
            e3_reg    <= e2_reg;
            t3b_reg   <= t3_reg;
            term2_reg <= term2_next;
            term3_reg <= term3_next;
            valid_reg <= e3_reg.valid;
            y_reg     <= y_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_y     = y_reg;

endmodule

/* hw/rtl/bezier_easing_y_from_x.sv */
`timescale 1ns / 1ps

// Channel  Ports                                             Direction
// input    s_valid s_ready s_x_progress s_ctrl1_x/y s_ctrl2_x/y  in
// result   m_valid m_ready m_y_eased                         out
//
// An input register comes first, then the iterations, then the final curve.
// A new word is taken every cycle while no result is stalled; each Newton-style iteration is three
// stages, one per multiply of the Horner form, and the final curve takes four.
// Reset clears only the valid bits of the stages.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.

module bezier_easing_y_from_x #(
    parameter int ITERATIONS = bey_pkg::ITERATIONS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [bey_pkg::XW-1:0] s_x_progress,
    input  logic [bey_pkg::XW-1:0] s_ctrl1_x,
    input  logic [bey_pkg::XW-1:0] s_ctrl1_y,
    input  logic [bey_pkg::XW-1:0] s_ctrl2_x,
    input  logic [bey_pkg::XW-1:0] s_ctrl2_y,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [bey_pkg::XW-1:0] m_y_eased
);
    import bey_pkg::*;

    logic en;
    bey_item_t in_reg, in_next;
    bey_item_t chain [ITERATIONS+1];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_comb begin
        in_next.valid = s_valid;
        in_next.diag  = (s_ctrl1_x == s_ctrl1_y) && (s_ctrl2_x == s_ctrl2_y);
        in_next.done  = 1'b0;
        in_next.x     = s_x_progress;
        in_next.ay    = s_ctrl1_y;
        in_next.by    = s_ctrl2_y;
        in_next.k0    = KW'(KW'(ONE) + 3 * KW'(s_ctrl1_x) - 3 * KW'(s_ctrl2_x));
        in_next.k1    = KW'(3 * KW'(s_ctrl2_x) - 6 * KW'(s_ctrl1_x));
        in_next.k2    = KW'(3 * KW'(s_ctrl1_x));
        in_next.t     = TW'(s_x_progress);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.valid <= 1'b0;
        end else if (en) begin
            in_reg <= in_next;
        end
    end

    assign chain[0] = in_reg;

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
        bey_iter u_iter (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_item  (chain[i]),
            .out_item (chain[i+1])
        );
    end

    bey_eval u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_item   (chain[ITERATIONS]),
        .out_valid (m_valid),
        .out_y     (m_y_eased)
    );

endmodule

/* hw/rtl/bey_checker.sv */
`timescale 1ns / 1ps

module bey_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [bey_pkg::XW-1:0] m_y_eased
);
    import bey_pkg::*;

    // A waiting result word holds its value until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_y_eased))
        else $error("result word changed while stalled");

    // The eased weight never leaves the unit interval.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_y_eased <= XW'(ONE))
        else $error("result word above one");

    // Input is refused only while a result waits downstream.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    // A free output side always lets the input advance.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled while output is free");

    // An offered input word stays offered until it is taken.
    a_offer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input word withdrawn before it was taken");

endmodule

bind bezier_easing_y_from_x bey_checker u_bey_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_y_eased (m_y_eased)
);
